/* rtl/generation_checked_handle_table_macros.svh */
// Assertion macros for the handle table.
`ifndef GENERATION_CHECKED_HANDLE_TABLE_MACROS_SVH
`define GENERATION_CHECKED_HANDLE_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GCHT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("handle table check failed");

// Next-cycle implication, checked outside reset.
`define GCHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("handle table check failed");

`endif

/* rtl/gcht_pkg.sv */
// Types and constants of the handle table.
`timescale 1ns / 1ps
`default_nettype none
package gcht_pkg;
    localparam int LEAF_SIZE    = 64;
    localparam int DIR_FANOUT   = 16;
    localparam int LEAF_LIMIT   = 64;
    localparam int MAX_GEN      = 255;
    localparam int PAYLOAD_BITS = 32;
    localparam int SLOT_COUNT   = LEAF_LIMIT * LEAF_SIZE;
    localparam int IDX_W        = 12;
    localparam int CNT_W        = 13;
    localparam int GEN_W        = 8;
    localparam int LEAF_W       = 7;
    localparam int LOFF_W       = $clog2(LEAF_SIZE);
    localparam int DIR_W        = $clog2(DIR_FANOUT);
    localparam int PAGE_W       = 7;

    typedef enum logic [2:0] {
        RC_OK     = 3'd0,
        RC_STATE  = 3'd1,
        RC_SLOTQ  = 3'd2,
        RC_GENEX  = 3'd3,
        RC_PAGEQ  = 3'd4,
        RC_HANDLE = 3'd5
    } rc_t;

    localparam logic [2:0] REQ_RESERVE  = 3'd0;
    localparam logic [2:0] REQ_COMMIT   = 3'd1;
    localparam logic [2:0] REQ_ROLLBACK = 3'd2;
    localparam logic [2:0] REQ_CLOSE    = 3'd3;
    localparam logic [2:0] REQ_LOOKUP   = 3'd4;

    localparam logic [1:0] SS_EMPTY       = 2'd0;
    localparam logic [1:0] SS_RESERVED    = 2'd1;
    localparam logic [1:0] SS_OCCUPIED    = 2'd2;
    localparam logic [1:0] SS_QUARANTINED = 2'd3;

    localparam logic [1:0] CFG_SLOT_QUOTA = 2'd0;
    localparam logic [1:0] CFG_PAGE_QUOTA = 2'd1;
    localparam logic [1:0] CFG_ACCEPTING  = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] link;
        logic [GEN_W-1:0] gen;
        logic [1:0]       st;
    } slot_ent_t;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_EX   = 8'b0000_0100,
        S_RCHK = 8'b0000_1000,
        S_RRD  = 8'b0001_0000,
        S_REX  = 8'b0010_0000,
        S_GROW = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } fsm_t;
endpackage
`default_nettype wire

/* rtl/generation_checked_handle_table.sv */
// Top level of the generation-checked handle table.
// One request at a time. Lookup, commit, rollback and close pass through
// acceptance, slot memory read, execute and the output register. Reserve
// passes a quota check, free-list read and execute, repeating these for each
// quarantined slot popped and skipped; growth writes a new leaf's 64 slot
// entries into the slot memory one per cycle; a reserve refused at once goes to output.
// Slot state, generation and free link share one memory with one read and
// one write port; payloads sit in a second memory.
`timescale 1ns / 1ps
`default_nettype none
`include "generation_checked_handle_table_macros.svh"
module generation_checked_handle_table
    import gcht_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [12:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // req_type[2:0], slot_index[14:3], handle_gen[22:15], payload_in[54:23]
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], handle_index[14:3], handle_gen_out[22:15], payload_out[54:23]
    output logic [55:0]      m_tdata
);
    slot_ent_t                ent_mem [SLOT_COUNT];
    logic [PAYLOAD_BITS-1:0]  pay_mem [SLOT_COUNT];

    fsm_t                     state_reg, state_next;
    logic [CNT_W-1:0]         slot_quota_reg;
    logic [PAGE_W-1:0]        page_quota_reg;
    logic                     accepting_reg;

    logic [2:0]               req_type_reg;
    logic [IDX_W-1:0]         req_idx_reg;
    logic [GEN_W-1:0]         req_gen_reg;
    logic [PAYLOAD_BITS-1:0]  req_pay_reg;

    logic [IDX_W-1:0]         free_top_reg;
    logic [CNT_W-1:0]         free_count_reg;
    logic [CNT_W-1:0]         live_count_reg;
    logic [CNT_W-1:0]         quar_count_reg;
    logic [LEAF_W-1:0]        leaf_count_reg;
    logic [PAGE_W-1:0]        pages_used_reg;
    logic [IDX_W-1:0]         grow_base_reg;
    logic [LOFF_W-1:0]        grow_cnt_reg;

    slot_ent_t                rd_ent_reg;
    logic [PAYLOAD_BITS-1:0]  rd_pay_reg;

    rc_t                      res_st_reg;
    logic [IDX_W-1:0]         res_idx_reg;
    logic [GEN_W-1:0]         res_gen_reg;
    logic [PAYLOAD_BITS-1:0]  res_pay_reg;
    logic                     m_tvalid_reg;
    logic [55:0]              m_tdata_reg;

    logic [IDX_W-1:0]         rd_addr;
    logic                     ent_we;
    logic [IDX_W-1:0]         ent_waddr;
    slot_ent_t                ent_wdata;
    logic                     pay_we;
    logic                     s_acc;
    logic                     out_free;
    logic [CNT_W-1:0]         slot_span;
    logic                     exists;
    logic                     gen_ok;
    logic                     need_root;
    logic                     need_mid;
    logic [PAGE_W:0]          page_need;
    logic [IDX_W-1:0]         grow_addr;
    rc_t                      ex_st;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign slot_span = {leaf_count_reg, {LOFF_W{1'b0}}};
    assign exists    = {1'b0, req_idx_reg} < slot_span;
    assign gen_ok    = exists && (req_gen_reg != '0) && (rd_ent_reg.gen == req_gen_reg);
    assign need_root = (leaf_count_reg == '0);
    assign need_mid  = (leaf_count_reg[DIR_W-1:0] == '0);
    assign page_need = {1'b0, pages_used_reg} + (PAGE_W+1)'(1)
                       + (PAGE_W+1)'(need_root) + (PAGE_W+1)'(need_mid);
    assign grow_addr = grow_base_reg | IDX_W'(grow_cnt_reg);

    always_comb begin
        priority case (1'b1)
            state_reg == S_RRD: rd_addr = free_top_reg;
            default:            rd_addr = req_idx_reg;
        endcase
    end

    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = req_idx_reg;
        ent_wdata = rd_ent_reg;
        pay_we    = 1'b0;
        unique case (state_reg)
            S_GROW: begin
                ent_we         = 1'b1;
                ent_waddr      = grow_addr;
                ent_wdata.st   = SS_EMPTY;
                ent_wdata.gen  = '0;
                ent_wdata.link = grow_addr + IDX_W'(1);
            end
            S_REX: begin
                ent_we    = 1'b1;
                ent_waddr = free_top_reg;
                if (rd_ent_reg.gen >= GEN_W'(MAX_GEN)) begin
                    ent_wdata.st = SS_QUARANTINED;
                end else begin
                    ent_wdata.st  = SS_RESERVED;
                    ent_wdata.gen = rd_ent_reg.gen + GEN_W'(1);
                end
            end
            S_EX: begin
                unique case (req_type_reg)
                    REQ_COMMIT: begin
                        if (accepting_reg && gen_ok && rd_ent_reg.st == SS_RESERVED) begin
                            ent_we       = 1'b1;
                            ent_wdata.st = SS_OCCUPIED;
                            pay_we       = 1'b1;
                        end
                    end
                    REQ_ROLLBACK, REQ_CLOSE: begin
                        if (gen_ok && rd_ent_reg.st == ((req_type_reg == REQ_ROLLBACK)
                                                        ? SS_RESERVED : SS_OCCUPIED)) begin
                            ent_we       = 1'b1;
                            ent_wdata.st = SS_EMPTY;
                            if (accepting_reg) begin
                                ent_wdata.link = free_top_reg;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ex_st = RC_STATE;
        unique case (req_type_reg)
            REQ_COMMIT: begin
                if (pay_we) begin
                    ex_st = RC_OK;
                end
            end
            REQ_ROLLBACK, REQ_CLOSE: begin
                if (!gen_ok) begin
                    ex_st = RC_HANDLE;
                end else if (ent_we) begin
                    ex_st = RC_OK;
                end
            end
            REQ_LOOKUP: begin
                if (!accepting_reg) begin
                    ex_st = RC_STATE;
                end else if (!gen_ok) begin
                    ex_st = RC_HANDLE;
                end else if (rd_ent_reg.st == SS_OCCUPIED) begin
                    ex_st = RC_OK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_ent_reg <= ent_mem[rd_addr];
        rd_pay_reg <= pay_mem[req_idx_reg];
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (pay_we) begin
            pay_mem[req_idx_reg] <= req_pay_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    state_next = (s_tdata[2:0] == REQ_RESERVE) ? S_RCHK : S_RD;
                end
            end
            S_RD:   state_next = S_EX;
            S_EX:   state_next = S_OUT;
            S_RCHK: begin
                if (!accepting_reg || live_count_reg >= slot_quota_reg) begin
                    state_next = S_OUT;
                end else if (free_count_reg != '0) begin
                    state_next = S_RRD;
                end else if ((quar_count_reg != '0 && slot_span == quar_count_reg
                              && (leaf_count_reg >= LEAF_W'(LEAF_LIMIT)
                                  || pages_used_reg >= page_quota_reg))
                             || leaf_count_reg >= LEAF_W'(LEAF_LIMIT)
                             || page_need > {1'b0, page_quota_reg}) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_GROW;
                end
            end
            S_RRD:  state_next = S_REX;
            S_REX:  state_next = (rd_ent_reg.gen >= GEN_W'(MAX_GEN)) ? S_RCHK : S_OUT;
            S_GROW: state_next = (grow_cnt_reg == '1) ? S_RCHK : S_GROW;
            S_OUT:  state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            slot_quota_reg <= CNT_W'(SLOT_COUNT);
            page_quota_reg <= PAGE_W'(69);
            accepting_reg  <= 1'b1;
            free_top_reg   <= '0;
            free_count_reg <= '0;
            live_count_reg <= '0;
            quar_count_reg <= '0;
            leaf_count_reg <= '0;
            pages_used_reg <= '0;
            grow_base_reg  <= '0;
            grow_cnt_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_SLOT_QUOTA: slot_quota_reg <= cfg_wdata;
                    CFG_PAGE_QUOTA: page_quota_reg <= cfg_wdata[PAGE_W-1:0];
                    CFG_ACCEPTING:  accepting_reg  <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_RCHK: begin
                    if (state_next == S_GROW) begin
                        grow_base_reg  <= slot_span[IDX_W-1:0];
                        grow_cnt_reg   <= '0;
                        leaf_count_reg <= leaf_count_reg + LEAF_W'(1);
                        pages_used_reg <= page_need[PAGE_W-1:0];
                    end
                end
                S_GROW: begin
                    grow_cnt_reg <= grow_cnt_reg + LOFF_W'(1);
                    if (grow_cnt_reg == '1) begin
                        free_top_reg   <= grow_base_reg;
                        free_count_reg <= CNT_W'(LEAF_SIZE);
                    end
                end
                S_REX: begin
                    free_top_reg   <= rd_ent_reg.link;
                    free_count_reg <= free_count_reg - CNT_W'(1);
                    if (rd_ent_reg.gen >= GEN_W'(MAX_GEN)) begin
                        quar_count_reg <= quar_count_reg + CNT_W'(1);
                    end else begin
                        live_count_reg <= live_count_reg + CNT_W'(1);
                    end
                end
                S_EX: begin
                    if (ent_we && ent_wdata.st == SS_EMPTY) begin
                        if (live_count_reg != '0) begin
                            live_count_reg <= live_count_reg - CNT_W'(1);
                        end
                        if (accepting_reg) begin
                            free_top_reg   <= req_idx_reg;
                            free_count_reg <= free_count_reg + CNT_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            req_type_reg <= s_tdata[2:0];
            req_idx_reg  <= s_tdata[14:3];
            req_gen_reg  <= s_tdata[22:15];
            req_pay_reg  <= s_tdata[54:23];
        end
        if (state_reg == S_OUT && out_free) begin
            m_tdata_reg <= {1'b0, res_pay_reg, res_gen_reg, res_idx_reg, res_st_reg};
        end
        unique case (state_reg)
            S_RCHK: begin
                res_idx_reg <= '0;
                res_gen_reg <= '0;
                res_pay_reg <= '0;
                if (!accepting_reg) begin
                    res_st_reg <= RC_STATE;
                end else if (live_count_reg >= slot_quota_reg) begin
                    res_st_reg <= RC_SLOTQ;
                end else if (quar_count_reg != '0 && slot_span == quar_count_reg
                             && (leaf_count_reg >= LEAF_W'(LEAF_LIMIT)
                                 || pages_used_reg >= page_quota_reg)) begin
                    res_st_reg <= RC_GENEX;
                end else begin
                    res_st_reg <= RC_PAGEQ;
                end
            end
            S_REX: begin
                res_st_reg  <= RC_OK;
                res_idx_reg <= free_top_reg;
                res_gen_reg <= rd_ent_reg.gen + GEN_W'(1);
            end
            S_EX: begin
                res_st_reg  <= ex_st;
                res_idx_reg <= pay_we ? req_idx_reg : '0;
                res_gen_reg <= pay_we ? req_gen_reg : '0;
                res_pay_reg <= (req_type_reg == REQ_LOOKUP && ex_st == RC_OK)
                               ? rd_pay_reg : '0;
            end
            default: begin
            end
        endcase
    end

    `GCHT_ASSERT_NEXT(a_accept_leaves_idle, s_acc, state_reg != S_IDLE)
    `GCHT_ASSERT_NEXT(a_grow_fills_list, state_reg == S_GROW && grow_cnt_reg == '1,
                      free_count_reg == CNT_W'(LEAF_SIZE) && state_reg == S_RCHK)
    `GCHT_ASSERT_NEXT(a_out_waits, state_reg == S_OUT && m_tvalid_reg && !m_tready,
                      state_reg == S_OUT)
    `GCHT_ASSERT_NOW(a_counts_bounded, 1'b1,
                     live_count_reg + quar_count_reg <= slot_span)
endmodule
`default_nettype wire

/* sim/generation_checked_handle_table_test.sv */
// Self-checking testbench for the generation-checked handle table.
`timescale 1ns / 1ps
`default_nettype none
module generation_checked_handle_table_test
    import gcht_pkg::*;
();

    typedef struct packed {
        logic [31:0] payload;
        logic [7:0]  gen;
        logic [11:0] index;
        logic [2:0]  status;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [12:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [55:0] s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [55:0] m_tdata;

    generation_checked_handle_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // table model
    logic [12:0] quota_slots;
    logic [6:0]  quota_pages;
    logic        open_flag;
    logic [1:0]  st_mem [SLOT_COUNT];
    int unsigned gen_mem [SLOT_COUNT];
    int unsigned link_mem [SLOT_COUNT];
    logic [31:0] pay_mem [SLOT_COUNT];
    int unsigned top_free, n_free, n_live, n_quar, n_leaves, n_pages;

    logic [55:0] pending_reqs [$];
    reply_t      expected_replies [$];
    int          errors = 0;
    int          send_idle = 10, recv_idle = 59;
    int          hold_cycles = 0;
    int          cycle = 0;
    int          n_ok = 0, n_genex = 0, n_pageq = 0, n_slotq = 0;

    // tready seen at the last rising edge, together with tvalid
    logic        s_tready_q = 1'b0;

    // handles known to the stimulus
    logic [11:0] held_idx [$];
    logic [7:0]  held_gen [$];

    function automatic void table_reset();
        quota_slots = 13'd4096; quota_pages = 7'd69; open_flag = 1'b1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            st_mem[i] = SS_EMPTY; gen_mem[i] = 0; link_mem[i] = 0; pay_mem[i] = '0;
        end
        top_free = 0; n_free = 0; n_live = 0; n_quar = 0; n_leaves = 0; n_pages = 0;
    endfunction

    function automatic void free_push(int unsigned i);
        link_mem[i] = top_free; top_free = i; n_free++;
    endfunction

    function automatic logic [2:0] reserve_slot(output int unsigned oi, output int unsigned og);
        int unsigned i, root, mid, need;
        oi = 0; og = 0;
        forever begin
            if (!open_flag) return RC_STATE;
            if (n_live >= quota_slots) return RC_SLOTQ;
            while (n_free != 0) begin
                i = top_free; top_free = link_mem[i]; n_free--;
                if (gen_mem[i] >= MAX_GEN) begin
                    st_mem[i] = SS_QUARANTINED; n_quar++;
                    continue;
                end
                gen_mem[i]++; st_mem[i] = SS_RESERVED; n_live++;
                oi = i; og = gen_mem[i];
                return RC_OK;
            end
            if (n_quar != 0 && n_leaves * LEAF_SIZE == n_quar
                    && (n_leaves >= LEAF_LIMIT || n_pages >= quota_pages))
                return RC_GENEX;
            if (n_leaves >= LEAF_LIMIT) return RC_PAGEQ;
            root = (n_leaves == 0); mid = (n_leaves % DIR_FANOUT == 0);
            need = 1 + root + mid;
            if (n_pages + need > quota_pages) return RC_PAGEQ;
            n_leaves++; n_pages += need;
            for (int k = LEAF_SIZE; k > 0; k--) begin
                i = (n_leaves - 1) * LEAF_SIZE + k - 1;
                st_mem[i] = SS_EMPTY; gen_mem[i] = 0; free_push(i);
            end
        end
    endfunction

    function automatic reply_t table_step(logic [55:0] d);
        reply_t r;
        logic [2:0]  op;
        int unsigned i, g, oi, og;
        logic        ok_gen;
        op = d[2:0]; i = d[14:3]; g = d[22:15];
        r = '0;
        r.status = RC_STATE;
        ok_gen = (i < n_leaves * LEAF_SIZE) && g != 0 && gen_mem[i] == g;
        case (op)
            REQ_RESERVE: begin
                r.status = reserve_slot(oi, og);
                if (r.status == RC_OK) begin
                    r.index = oi; r.gen = og;
                end
            end
            REQ_COMMIT: begin
                if (open_flag && ok_gen && st_mem[i] == SS_RESERVED) begin
                    pay_mem[i] = d[54:23]; st_mem[i] = SS_OCCUPIED;
                    r.status = RC_OK; r.index = i; r.gen = g;
                end
            end
            REQ_ROLLBACK, REQ_CLOSE: begin
                if (!ok_gen) r.status = RC_HANDLE;
                else if (st_mem[i] == (op == REQ_ROLLBACK ? SS_RESERVED : SS_OCCUPIED)) begin
                    st_mem[i] = SS_EMPTY;
                    if (n_live != 0) n_live--;
                    if (open_flag) free_push(i);
                    r.status = RC_OK;
                end
            end
            REQ_LOOKUP: begin
                if (!open_flag) r.status = RC_STATE;
                else if (!ok_gen) r.status = RC_HANDLE;
                else if (st_mem[i] == SS_OCCUPIED) begin
                    r.status = RC_OK; r.payload = pay_mem[i];
                end
            end
            default: r.status = RC_STATE;
        endcase
        return r;
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_q) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
                    s_tdata <= pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver, with its own hold-off count
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        s_tready_q <= s_tvalid && s_tready;
        cycle <= cycle + 1;
        if (aresetn && s_tvalid && s_tready)
            expected_replies.push_back(table_step(s_tdata));
    end

    // monitor
    always @(posedge aclk) begin : monitor
        reply_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[54:0];
            if (expected_replies.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                case (want.status)
                    RC_OK:    n_ok++;
                    RC_GENEX: n_genex++;
                    RC_PAGEQ: n_pageq++;
                    RC_SLOTQ: n_slotq++;
                    default: ;
                endcase
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.index !== want.index) begin
                    $error("handle_index: expected %0d, got %0d", want.index, got.index);
                    errors++;
                end
                if (got.gen !== want.gen) begin
                    $error("handle_gen_out: expected %0d, got %0d", want.gen, got.gen);
                    errors++;
                end
                if (got.payload !== want.payload) begin
                    $error("payload_out: expected %h, got %h", want.payload, got.payload);
                    errors++;
                end
                if (want.status == RC_OK && want.gen != 0) begin
                    held_idx.push_back(want.index);
                    held_gen.push_back(want.gen);
                    if (held_idx.size() > 48) begin
                        void'(held_idx.pop_front());
                        void'(held_gen.pop_front());
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle > 3000000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [55:0] make_req(logic [2:0] op, logic [11:0] i,
                                             logic [7:0] g, logic [31:0] p);
        return {1'b0, p, g, i, op};
    endfunction

    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid || expected_replies.size() != 0)
            @(posedge aclk);
        repeat (40 * 70) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] a, logic [12:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_addr <= a; cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (a)
            CFG_SLOT_QUOTA: quota_slots = v;
            CFG_PAGE_QUOTA: quota_pages = v[6:0];
            CFG_ACCEPTING:  open_flag = v[0];
            default: ;
        endcase
    endtask

    task automatic add_random(int n);
        int k, sel;
        logic [11:0] i;
        logic [7:0]  g;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if (held_idx.size() != 0 && sel < 70) begin
                int h;
                h = $urandom_range(held_idx.size() - 1);
                i = held_idx[h]; g = held_gen[h];
                if ($urandom_range(9) == 0) g = g + 8'd1;
                pending_reqs.push_back(make_req(3'($urandom_range(1, 4)), i, g, $urandom));
            end else if (sel < 90) begin
                pending_reqs.push_back(make_req(REQ_RESERVE, 12'($urandom), 8'($urandom),
                                                $urandom));
            end else begin
                pending_reqs.push_back(make_req(3'($urandom_range(7)), 12'($urandom),
                                                8'($urandom), $urandom));
            end
        end
    endtask

    initial begin
        table_reset();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed
        pending_reqs.push_back(make_req(REQ_LOOKUP, 12'd0, 8'd1, 32'h0));
        pending_reqs.push_back(make_req(REQ_RESERVE, 12'hFFF, 8'hFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(REQ_COMMIT, 12'd0, 8'd1, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(REQ_LOOKUP, 12'd0, 8'd1, 32'h0));
        pending_reqs.push_back(make_req(REQ_LOOKUP, 12'd0, 8'd0, 32'h0));
        pending_reqs.push_back(make_req(REQ_LOOKUP, 12'hFFF, 8'd1, 32'h0));
        pending_reqs.push_back(make_req(REQ_COMMIT, 12'hFFF, 8'd1, 32'h0));
        pending_reqs.push_back(make_req(REQ_ROLLBACK, 12'd0, 8'd1, 32'h0));
        pending_reqs.push_back(make_req(REQ_CLOSE, 12'd0, 8'd1, 32'h0));
        pending_reqs.push_back(make_req(REQ_RESERVE, 12'd0, 8'd0, 32'h0));
        pending_reqs.push_back(make_req(REQ_ROLLBACK, 12'd1, 8'd1, 32'h0));
        pending_reqs.push_back(make_req(3'd5, 12'd0, 8'd0, 32'h0));
        pending_reqs.push_back(make_req(3'd7, 12'hFFF, 8'hFF, 32'hFFFF_FFFF));
        drain();

        // one slot cycled to its last generation, then quarantined
        for (int k = 0; k < 256; k++) begin
            pending_reqs.push_back(make_req(REQ_RESERVE, 12'd0, 8'd0, 32'h0));
            pending_reqs.push_back(make_req(REQ_ROLLBACK, 12'd0, 8'(k + 2), 32'h0));
        end
        drain();

        // retiring, then accepting again
        write_reg(CFG_ACCEPTING, 13'd0);
        pending_reqs.push_back(make_req(REQ_RESERVE, 12'd0, 8'd0, 32'h0));
        pending_reqs.push_back(make_req(REQ_COMMIT, 12'd1, 8'd1, 32'h0));
        pending_reqs.push_back(make_req(REQ_LOOKUP, 12'd0, 8'd1, 32'h0));
        pending_reqs.push_back(make_req(REQ_CLOSE, 12'd0, 8'd1, 32'h0));
        pending_reqs.push_back(make_req(REQ_ROLLBACK, 12'd1, 8'd1, 32'h0));
        drain();
        write_reg(CFG_ACCEPTING, 13'd1);

        add_random(300);
        drain();

        // tight quotas
        write_reg(CFG_SLOT_QUOTA, 13'd3);
        write_reg(CFG_PAGE_QUOTA, 13'd0);
        add_random(150);
        drain();
        write_reg(CFG_SLOT_QUOTA, 13'd0);
        add_random(40);
        drain();

        send_idle = 59; recv_idle = 10;
        write_reg(CFG_SLOT_QUOTA, 13'd8191);
        write_reg(CFG_PAGE_QUOTA, 13'd127);
        hold_cycles = 300;
        add_random(300);
        drain();

        // grow to the page quota limit
        write_reg(CFG_PAGE_QUOTA, 13'd6);
        for (int k = 0; k < 200; k++)
            pending_reqs.push_back(make_req(REQ_RESERVE, 12'd0, 8'd0, 32'h0));
        drain();

        send_idle = 0; recv_idle = 0;
        write_reg(CFG_PAGE_QUOTA, 13'd69);
        add_random(200);
        drain();

        $display("Covered %0d ok, %0d slot quota, %0d page quota, %0d exhausted results.",
                 n_ok, n_slotq, n_pageq, n_genex);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
+incdir+rtl
rtl/gcht_pkg.sv
rtl/generation_checked_handle_table.sv
sim/generation_checked_handle_table_test.sv
